// File: rtl/core/sem_pkg.sv
package sem_pkg;

  // configuration register map
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // register widths and reset values
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 16;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

  // result fields
  localparam int MAG_BITS    = 11;
  localparam int OUT_TDATA_W = 16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // latch pixel, read line stores
    logic load;       // write line stores, kernels, shift window, step counters
    logic square;     // squares and sum, start square root
    logic root_step;  // one square root iteration
    logic out_load;   // move root and flag into the output register
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pos_valid;  // current pixel sits at a full window position
    logic root_last;  // square root is on its final iteration
  } dp_status_t;

endpackage

// File: rtl/core/sobel_edge_magnitude_unit.sv
// sequence: a pixel at a full window position is accepted, then passes through load, square,
//   PIXEL_BITS+3 square root iterations and output load; other pixels only accept and load
// a new pixel is taken only once the last one is through, held by the bit-per-cycle
//   square root unit and by a full output register; the output register holds one result
// reset: clears counters, window and control; registers return to 640 x 480;
//   line stores are not cleared and need no sweep
module sobel_edge_magnitude_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]    in_tdata,   // [PIXEL_BITS-1:0] pixel
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sem_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [10:0] magnitude
  output logic                               out_tuser,  // [0] frame_end
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [sem_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sem_pkg::*;

  logic [WIDTH_BITS-1:0]  frame_width_r;
  logic [HEIGHT_BITS-1:0] frame_height_r;
  logic [MAG_BITS-1:0]    magnitude;
  dp_cmd_t                cmd;
  dp_status_t             status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  sem_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  sem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel        (in_tdata[PIXEL_BITS-1:0]),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .cmd          (cmd),
    .status       (status),
    .magnitude    (magnitude),
    .frame_end    (out_tuser)
  );

  assign out_tdata = {(OUT_TDATA_W - MAG_BITS)'(0), magnitude};

endmodule

// File: rtl/core/sem_datapath.sv
module sem_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [PIXEL_BITS-1:0]            pixel,
  input  logic [sem_pkg::WIDTH_BITS-1:0]   frame_width,
  input  logic [sem_pkg::HEIGHT_BITS-1:0]  frame_height,
  input  sem_pkg::dp_cmd_t                 cmd,
  output sem_pkg::dp_status_t              status,
  output logic [sem_pkg::MAG_BITS-1:0]     magnitude,
  output logic                             frame_end
);
  import sem_pkg::*;

  localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMPW = (COLW + 1 > WIDTH_BITS) ? COLW + 1 : WIDTH_BITS;
  localparam int SUMW = PIXEL_BITS + 2;   // one kernel column sum
  localparam int GW   = PIXEL_BITS + 3;   // signed gradient
  localparam int SQW  = 2 * PIXEL_BITS + 6;

  // line stores: previous row and the row before it
  logic [PIXEL_BITS-1:0] mid_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] top_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] top_q, mid_q, bot_r;

  logic [COLW-1:0]        col_r;
  logic [HEIGHT_BITS-1:0] row_r;

  // window columns: left and center
  logic [PIXEL_BITS-1:0] lt_r, lm_r, lb_r, ct_r, cm_r, cb_r;

  logic [GW-2:0] ax_r, ay_r;
  logic          fe_r;

  logic [SQW-1:0] v_r;
  logic [SQW:0]   res_r, bit_r;

  // effective frame size
  logic [CMPW-1:0]        w_ext, eff_w;
  logic [HEIGHT_BITS-1:0] eff_h;
  logic                   last_col, last_row;

  assign w_ext = CMPW'(frame_width);
  assign eff_w = (w_ext < CMPW'(3)) ? CMPW'(3) :
                 (w_ext > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : w_ext;
  assign eff_h = (frame_height < HEIGHT_BITS'(3)) ? HEIGHT_BITS'(3) : frame_height;
  assign last_col = (CMPW'(col_r) + CMPW'(1)) >= eff_w;
  assign last_row = ({1'b0, row_r} + 17'd1) >= {1'b0, eff_h};

  assign status.pos_valid = (row_r >= HEIGHT_BITS'(2)) && (col_r >= COLW'(2));
  assign status.root_last = bit_r[0];

  // gradients
  logic [SUMW-1:0] s_left, s_right, s_top, s_bot;
  logic signed [GW-1:0] gx, gy;
  logic [GW-2:0] ax, ay;

  always_comb begin
    s_left  = SUMW'(lt_r) + {1'b0, lm_r, 1'b0} + SUMW'(lb_r);
    s_right = SUMW'(top_q) + {1'b0, mid_q, 1'b0} + SUMW'(bot_r);
    s_top   = SUMW'(lt_r) + {1'b0, ct_r, 1'b0} + SUMW'(top_q);
    s_bot   = SUMW'(lb_r) + {1'b0, cb_r, 1'b0} + SUMW'(bot_r);
    gx = $signed({1'b0, s_left}) - $signed({1'b0, s_right});
    gy = $signed({1'b0, s_top}) - $signed({1'b0, s_bot});
    ax = gx[GW-1] ? (GW-1)'(-gx) : gx[GW-2:0];
    ay = gy[GW-1] ? (GW-1)'(-gy) : gy[GW-2:0];
  end

  // squares of the gradient magnitudes
  logic [2*GW-3:0] ax_sq, ay_sq;
  assign ax_sq = ax_r * ax_r;
  assign ay_sq = ay_r * ay_r;

  // square root trial
  logic [SQW:0] trial;
  assign trial = res_r + bit_r;

  // line store access
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      top_q <= top_mem[col_r];
      mid_q <= mid_mem[col_r];
      bot_r <= pixel;
    end
    if (cmd.load) begin
      top_mem[col_r] <= mid_q;
      mid_mem[col_r] <= bot_r;
    end
  end

  // counters and window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      lt_r  <= '0;
      lm_r  <= '0;
      lb_r  <= '0;
      ct_r  <= '0;
      cm_r  <= '0;
      cb_r  <= '0;
    end else if (cmd.load) begin
      lt_r <= ct_r;
      lm_r <= cm_r;
      lb_r <= cb_r;
      ct_r <= top_q;
      cm_r <= mid_q;
      cb_r <= bot_r;
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + HEIGHT_BITS'(1);
      end else begin
        col_r <= col_r + COLW'(1);
      end
    end
  end

  // gradient magnitudes, squares and bitwise square root
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= ax;
      ay_r <= ay;
      fe_r <= last_col && last_row;
    end
    if (cmd.square) begin
      v_r   <= SQW'(ax_sq) + SQW'(ay_sq);
      res_r <= '0;
      bit_r <= (SQW + 1)'(1) << (SQW - 2);
    end else if (cmd.root_step) begin
      if ({1'b0, v_r} >= trial) begin
        v_r   <= v_r - SQW'(trial);
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      magnitude <= MAG_BITS'(res_r);
      frame_end <= fe_r;
    end
  end

endmodule

// File: rtl/core/sem_ctrl.sv
module sem_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  sem_pkg::dp_status_t status,
  output sem_pkg::dp_cmd_t    cmd
);
  import sem_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SQUARE,
    S_ROOT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // commands decoded from state and the stream handshakes
  always_comb begin
    cmd           = '0;
    cmd.accept    = (state_r == S_IDLE) && in_tvalid;
    cmd.load      = (state_r == S_LOAD);
    cmd.square    = (state_r == S_SQUARE);
    cmd.root_step = (state_r == S_ROOT);
    cmd.out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_LOAD;
      S_LOAD:   state_nxt = status.pos_valid ? S_SQUARE : S_IDLE;
      S_SQUARE: state_nxt = S_ROOT;
      S_ROOT:   if (status.root_last) state_nxt = S_DONE;
      S_DONE:   if (cmd.out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a full output register is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

  // an accepted pixel goes straight to the load step
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_LOAD))
    else $error("accepted pixel not loaded");

  // the last root iteration hands over to the output step
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT && status.root_last) |=> (state_r == S_DONE))
    else $error("square root did not finish");

  // a result leaves only when taken
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_tready))
    else $error("result dropped");

endmodule

// File: test/sem_magnitude_checker.sv
`timescale 1ns / 1ps

module sem_magnitude_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [sem_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  input  logic                            cfg_wr_en,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              error_count,
  output int                              pending_results
);
  import sem_pkg::*;

  typedef struct packed {
    logic [MAG_BITS-1:0] magnitude;
    logic                frame_end;
  } edge_result_t;

  edge_result_t expected_results[$];

  // shadow line stores: previous row and the row before it
  logic [7:0] prev_row  [MAX_WIDTH];
  logic [7:0] older_row [MAX_WIDTH];

  // two stored window columns: index 0 is left, 1 is center
  logic [7:0] win_top [2];
  logic [7:0] win_mid [2];
  logic [7:0] win_bot [2];

  logic [WIDTH_BITS-1:0]  frame_width_q;
  logic [HEIGHT_BITS-1:0] frame_height_q;
  int unsigned            col_pos;
  int unsigned            row_pos;
  int                     errors = 0;

  assign error_count = errors;

  task automatic report_mismatch(input string what);
    $display("[%0t ns] %s", $realtime, what);
    errors++;
  endtask

  // bitwise search for the integer square root
  function automatic logic [MAG_BITS-1:0] floor_root(input int unsigned radicand);
    int unsigned root;
    int unsigned trial;
    int          b;
    root = 0;
    for (b = MAG_BITS - 1; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root[MAG_BITS-1:0];
  endfunction

  // one accepted pixel: predict its result, update line stores, window and counters
  task automatic predict_edge(input logic [7:0] pix);
    int unsigned  w;
    int unsigned  h;
    int unsigned  col;
    logic [7:0]   above2;
    logic [7:0]   above1;
    int           lt, lm, lb, ct, cb, rt, rm, rb;
    int           gx, gy;
    edge_result_t res;
    w = (frame_width_q < 3) ? 3 :
        ((frame_width_q > MAX_WIDTH) ? MAX_WIDTH : int'(frame_width_q));
    h = (frame_height_q < 3) ? 3 : int'(frame_height_q);
    col = col_pos % MAX_WIDTH;
    above2 = older_row[col];
    above1 = prev_row[col];
    older_row[col] = above1;
    prev_row[col]  = pix;

    if (row_pos >= 2 && col >= 2) begin
      lt = int'(win_top[0]);
      lm = int'(win_mid[0]);
      lb = int'(win_bot[0]);
      ct = int'(win_top[1]);
      cb = int'(win_bot[1]);
      rt = int'(above2);
      rm = int'(above1);
      rb = int'(pix);
      gx = (lt + 2 * lm + lb) - (rt + 2 * rm + rb);
      gy = (lt + 2 * ct + rt) - (lb + 2 * cb + rb);
      res.magnitude = floor_root(gx * gx + gy * gy);
      res.frame_end = (col + 1 >= w) && (row_pos + 1 >= h);
      expected_results.push_back(res);
    end

    win_top[0] = win_top[1];
    win_mid[0] = win_mid[1];
    win_bot[0] = win_bot[1];
    win_top[1] = above2;
    win_mid[1] = above1;
    win_bot[1] = pix;

    // counters past the frame after a register change end the row or frame
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : ((row_pos + 1) & 32'hFFFF);
    end else begin
      col_pos = col + 1;
    end
  endtask

  task automatic check_result();
    edge_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result: magnitude %0d frame_end %0b",
                                out_tdata[MAG_BITS-1:0], out_tuser));
      return;
    end
    want = expected_results.pop_front();
    if (out_tdata[MAG_BITS-1:0] !== want.magnitude)
      report_mismatch($sformatf("magnitude: got %0d expected %0d",
                                out_tdata[MAG_BITS-1:0], want.magnitude));
    if (out_tuser !== want.frame_end)
      report_mismatch($sformatf("frame_end: got %0b expected %0b (magnitude %0d)",
                                out_tuser, want.frame_end, want.magnitude));
  endtask

  // monitor: configuration, results, then pixels
  always @(posedge clk) begin
    if (!rst_n) begin
      frame_width_q  = WIDTH_RESET;
      frame_height_q = HEIGHT_RESET;
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < 2; i++) begin
        win_top[i] = '0;
        win_mid[i] = '0;
        win_bot[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_FRAME_WIDTH)
          frame_width_q = cfg_wdata[WIDTH_BITS-1:0];
        else if (cfg_index == REG_FRAME_HEIGHT)
          frame_height_q = cfg_wdata[HEIGHT_BITS-1:0];
      end
      if (out_tvalid && out_tready)
        check_result();
      if (in_tvalid && in_tready)
        predict_edge(in_tdata);
    end
    pending_results <= expected_results.size();
  end

endmodule

// File: test/sobel_edge_magnitude_unit_tb.sv
`timescale 1ns / 1ps

module sobel_edge_magnitude_unit_tb;
  import sem_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int PIXEL_BITS    = 8;
  localparam int BLOCK_LATENCY = PIXEL_BITS + 7;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 970;
  localparam int WIDE_PIXELS   = 40;

  // strong diagonal edge and its inverse
  localparam logic [7:0] CORNER_PATCH [9] = '{8'd255, 8'd255, 8'd0,
                                              8'd255, 8'd0,   8'd0,
                                              8'd255, 8'd0,   8'd0};

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int error_count;
  int pending_results;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int idle_cycles        = 0;

  // stimulus-side view of the raster position and the written registers
  int unsigned width_raw  = WIDTH_RESET;
  int unsigned height_raw = HEIGHT_RESET;
  int unsigned pos_col    = 0;
  int unsigned pos_row    = 0;

  always #4 clk = ~clk;

  sobel_edge_magnitude_unit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  sem_magnitude_checker #(
    .MAX_WIDTH (MAX_WIDTH)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("sobel_edge_magnitude_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned active_width();
    if (width_raw < 3) return 3;
    if (width_raw > MAX_WIDTH) return MAX_WIDTH;
    return width_raw;
  endfunction

  function automatic void advance(inout int unsigned c, inout int unsigned r);
    int unsigned h;
    h = (height_raw < 3) ? 3 : height_raw;
    c = c % MAX_WIDTH;
    if (c + 1 >= active_width()) begin
      c = 0;
      r = (r + 1 >= h) ? 0 : ((r + 1) & 32'hFFFF);
    end else begin
      c = c + 1;
    end
  endfunction

  // pixels left until the counters wrap to the frame origin
  function automatic int unsigned pixels_to_origin();
    int unsigned c;
    int unsigned r;
    int unsigned n;
    c = pos_col;
    r = pos_row;
    n = 0;
    do begin
      advance(c, r);
      n++;
    end while (!(c == 0 && r == 0) && n < 4096);
    return n;
  endfunction

  function automatic logic [7:0] random_pixel();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic int unsigned random_height();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8)  return $urandom_range(2);
    if (pick < 85) return $urandom_range(7, 3);
    if (pick < 95) return $urandom_range(12, 8);
    return $urandom_range(65535, 13);
  endfunction

  task automatic send_pixel(input logic [7:0] pix);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance(pos_col, pos_row);
  endtask

  // stop sending, wait for every result, then for the pipeline to go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (BLOCK_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_FRAME_WIDTH)
      width_raw = val & 32'h7FF;
    else
      height_raw = val & 32'hFFFF;
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned count;
    int          pick;
    bit          at_origin;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: widths and heights below the minimum act as 3
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    foreach (CORNER_PATCH[i]) send_pixel(CORNER_PATCH[i]);
    repeat (9) send_pixel(8'd255);
    settle();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 2);
    foreach (CORNER_PATCH[i]) send_pixel(8'd255 - CORNER_PATCH[i]);

    // oversized width is clamped to the line store size; a partial row runs at it
    settle();
    write_reg(REG_FRAME_WIDTH, 2047);
    write_reg(REG_FRAME_HEIGHT, 3);
    send_random(WIDE_PIXELS);

    // tallest frame, left open so later shrinks push counters past the end
    settle();
    write_reg(REG_FRAME_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 65535);
    send_random(14);

    // random episodes of register changes and pixel runs
    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      case (random_sent * 4 / RANDOM_PIXELS)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
        default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
      endcase
      settle();
      at_origin = (pos_col == 0 && pos_row == 0);
      pick = $urandom_range(3);
      // width may only grow at the frame origin, so line stores stay written
      if (pick != 1) begin
        if (at_origin) begin
          case ($urandom_range(9))
            0:       write_reg(REG_FRAME_WIDTH, $urandom_range(2));
            1:       write_reg(REG_FRAME_WIDTH, $urandom_range(40, 13));
            default: write_reg(REG_FRAME_WIDTH, $urandom_range(12, 3));
          endcase
        end else begin
          write_reg(REG_FRAME_WIDTH, $urandom_range(active_width()));
        end
      end
      if (pick != 0)
        write_reg(REG_FRAME_HEIGHT, random_height());
      count = pixels_to_origin();
      if ($urandom_range(3) == 0 || count > 300)
        count = $urandom_range(25, 1);
      send_random(count);
      random_sent += count;
    end

    settle();
    if (error_count == 0)
      $display("sobel_edge_magnitude_unit verification clean");
    else
      $display("sobel_edge_magnitude_unit verification failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sem_pkg.sv
rtl/core/sem_datapath.sv
rtl/core/sem_ctrl.sv
rtl/core/sobel_edge_magnitude_unit.sv
test/sem_magnitude_checker.sv
test/sobel_edge_magnitude_unit_tb.sv
